FILE: hdl/jsu_pkg.sv
// shared types, codes and decode helpers for the json string unescaper
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_QUOTE  = 3'd1,
    ERR_TRUNC_ESC = 3'd2,
    ERR_TRUNC_UNI = 3'd3,
    ERR_BAD_HEX   = 3'd4,
    ERR_UNK_ESC   = 3'd5,
    ERR_UNTERM    = 3'd6
  } err_e;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  // {ok, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // {ok, byte} for single-byte escapes, u is handled by the caller
  function automatic logic [8:0] esc_value(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      CH_QUOTE:     r = {1'b1, CH_QUOTE};
      CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
      CH_SLASH:     r = {1'b1, CH_SLASH};
      8'h6E:        r = {1'b1, 8'h0A};
      8'h72:        r = {1'b1, 8'h0D};
      8'h74:        r = {1'b1, 8'h09};
      8'h62:        r = {1'b1, 8'h08};
      8'h66:        r = {1'b1, 8'h0C};
      default:      r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/json_string_unescaper.sv
// json string unescaper: streaming decoder of one json string literal
`timescale 1ns / 1ps

// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+------------------------------------------
// in      | input     | in_valid_i / in_stall_o   | func_i, in_byte_i
// out     | output    | out_valid_o / out_stall_i | out_byte_o, byte_valid_o, status_o,
//         |           |                           | error_code_o, run_last_o
//
// an accepted item is registered in the input register, is decoded and lands in the
// result buffer once the buffer can take it
// one item per cycle unless out_stall_i holds results; the fourth hex digit of a \u escape gives
// one, two or three results, and the next item waits in the input register while the buffer drains
// the input register takes a new item while results still wait downstream
// reset clears the decoder state to waiting for an opening quote and empties both stages

module json_string_unescaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic [1:0] status_o,
  output logic [2:0] error_code_o,
  output logic       run_last_o
);

  // input register
  logic       in_vld_q;
  logic       func_q;
  logic [7:0] byte_q;

  // decoder state
  jsu_pkg::phase_e phase_q, phase_d;
  logic [1:0]      hex_cnt_q, hex_cnt_d;
  logic [15:0]     code_q, code_d;
  logic            bad_q, bad_d;

  // result buffer, head at index 0
  logic [7:0]       res_byte_q [3];
  logic [1:0]       res_cnt_q;
  logic             res_bv_q;
  jsu_pkg::status_e res_st_q;
  jsu_pkg::err_e    res_err_q;

  // results of the item in the input register
  logic [7:0]       r_byte [3];
  logic [1:0]       r_cnt;
  logic             r_bv;
  jsu_pkg::status_e r_st;
  jsu_pkg::err_e    r_err;

  logic        take;
  logic        advance;
  logic [4:0]  hv;
  logic [8:0]  ev;
  logic [15:0] cp;
  logic        bad_nxt;

  // result handshake and when the decoded item may move into the buffer
  assign take    = out_valid_o && !out_stall_i;
  assign advance = in_vld_q && ((res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && take));
  assign in_stall_o = in_vld_q && !advance;

  assign hv      = jsu_pkg::hex_value(byte_q);
  assign ev      = jsu_pkg::esc_value(byte_q);
  assign cp      = {code_q[11:0], hv[3:0]};
  assign bad_nxt = bad_q || !hv[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      func_q <= func_i;
      byte_q <= in_byte_i;
    end
  end

  // next decoder state
  always_comb begin
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    code_d    = code_q;
    bad_d     = bad_q;
    case (phase_q)
      jsu_pkg::PH_WAIT: begin
        if (!func_q && byte_q == jsu_pkg::CH_QUOTE) phase_d = jsu_pkg::PH_BODY;
      end
      jsu_pkg::PH_BODY: begin
        if (func_q || byte_q == jsu_pkg::CH_QUOTE) begin
          phase_d = jsu_pkg::PH_WAIT;
        end else if (byte_q == jsu_pkg::CH_BACKSLASH) begin
          phase_d = jsu_pkg::PH_ESC;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (func_q) begin
          phase_d = jsu_pkg::PH_WAIT;
        end else if (byte_q == jsu_pkg::CH_U) begin
          phase_d   = jsu_pkg::PH_HEX;
          hex_cnt_d = 2'd0;
          code_d    = 16'd0;
          bad_d     = 1'b0;
        end else if (ev[8]) begin
          phase_d = jsu_pkg::PH_BODY;
        end else begin
          phase_d = jsu_pkg::PH_WAIT;
        end
      end
      jsu_pkg::PH_HEX: begin
        if (func_q) begin
          phase_d   = jsu_pkg::PH_WAIT;
          hex_cnt_d = 2'd0;
        end else begin
          code_d = cp;
          bad_d  = bad_nxt;
          if (hex_cnt_q != 2'd3) begin
            hex_cnt_d = hex_cnt_q + 2'd1;
          end else begin
            hex_cnt_d = 2'd0;
            phase_d   = bad_nxt ? jsu_pkg::PH_WAIT : jsu_pkg::PH_BODY;
          end
        end
      end
      default: phase_d = jsu_pkg::PH_WAIT;
    endcase
  end

  // results of the current item
  always_comb begin
    r_byte[0] = 8'd0;
    r_byte[1] = 8'd0;
    r_byte[2] = 8'd0;
    r_cnt     = 2'd1;
    r_bv      = 1'b0;
    r_st      = jsu_pkg::ST_RUN;
    r_err     = jsu_pkg::ERR_NONE;
    case (phase_q)
      jsu_pkg::PH_WAIT: begin
        if (func_q || byte_q != jsu_pkg::CH_QUOTE) begin
          r_st  = jsu_pkg::ST_ERR;
          r_err = jsu_pkg::ERR_NO_QUOTE;
        end
      end
      jsu_pkg::PH_BODY: begin
        if (func_q) begin
          r_st  = jsu_pkg::ST_ERR;
          r_err = jsu_pkg::ERR_UNTERM;
        end else if (byte_q == jsu_pkg::CH_QUOTE) begin
          r_st = jsu_pkg::ST_DONE;
        end else if (byte_q != jsu_pkg::CH_BACKSLASH) begin
          r_byte[0] = byte_q;
          r_bv      = 1'b1;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (func_q) begin
          r_st  = jsu_pkg::ST_ERR;
          r_err = jsu_pkg::ERR_TRUNC_ESC;
        end else if (byte_q == jsu_pkg::CH_U) begin
          r_bv = 1'b0;
        end else if (ev[8]) begin
          r_byte[0] = ev[7:0];
          r_bv      = 1'b1;
        end else begin
          r_st  = jsu_pkg::ST_ERR;
          r_err = jsu_pkg::ERR_UNK_ESC;
        end
      end
      jsu_pkg::PH_HEX: begin
        if (func_q) begin
          r_st  = jsu_pkg::ST_ERR;
          r_err = jsu_pkg::ERR_TRUNC_UNI;
        end else if (hex_cnt_q == 2'd3) begin
          if (bad_nxt) begin
            r_st  = jsu_pkg::ST_ERR;
            r_err = jsu_pkg::ERR_BAD_HEX;
          end else begin
            r_bv = 1'b1;
            if (cp[15:7] == 9'd0) begin
              r_byte[0] = cp[7:0];
            end else if (cp[15:11] == 5'd0) begin
              // two-byte utf-8
              r_cnt     = 2'd2;
              r_byte[0] = jsu_pkg::UTF8_LEAD2 | {3'd0, cp[10:6]};
              r_byte[1] = jsu_pkg::UTF8_CONT | {2'd0, cp[5:0]};
            end else begin
              // three-byte utf-8
              r_cnt     = 2'd3;
              r_byte[0] = jsu_pkg::UTF8_LEAD3 | {4'd0, cp[15:12]};
              r_byte[1] = jsu_pkg::UTF8_CONT | {2'd0, cp[11:6]};
              r_byte[2] = jsu_pkg::UTF8_CONT | {2'd0, cp[5:0]};
            end
          end
        end
      end
      default: begin
        r_st  = jsu_pkg::ST_ERR;
        r_err = jsu_pkg::ERR_NO_QUOTE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= jsu_pkg::PH_WAIT;
      hex_cnt_q <= 2'd0;
      code_q    <= 16'd0;
      bad_q     <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (advance) begin
        phase_q   <= phase_d;
        hex_cnt_q <= hex_cnt_d;
        code_q    <= code_d;
        bad_q     <= bad_d;
        res_cnt_q <= r_cnt;
      end else if (take) begin
        res_cnt_q <= res_cnt_q - 2'd1;
      end
    end
  end

  // buffer payload, shifts toward the head as results leave
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_byte_q[0] <= r_byte[0];
      res_byte_q[1] <= r_byte[1];
      res_byte_q[2] <= r_byte[2];
      res_bv_q      <= r_bv;
      res_st_q      <= r_st;
      res_err_q     <= r_err;
    end else if (take) begin
      res_byte_q[0] <= res_byte_q[1];
      res_byte_q[1] <= res_byte_q[2];
    end
  end

  assign out_valid_o  = (res_cnt_q != 2'd0);
  assign out_byte_o   = res_byte_q[0];
  assign byte_valid_o = res_bv_q;
  assign status_o     = res_st_q;
  assign error_code_o = res_err_q;
  assign run_last_o   = (res_cnt_q == 2'd1);

  // a done or error result always ends its item and carries no byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != jsu_pkg::ST_RUN) |-> (run_last_o && !byte_valid_o))
    else $error("done or error result is not the last of its item");

  // an error code shows exactly with the error status
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == jsu_pkg::ST_ERR) == (error_code_o != jsu_pkg::ERR_NONE)))
    else $error("error code does not match status");

  // hex digits are counted only inside a \u escape
  a_hex_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hex_cnt_q != 2'd0) |-> (phase_q == jsu_pkg::PH_HEX))
    else $error("hex count outside a unicode escape");

  // the buffer never loads over undelivered results
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (res_cnt_q == $past(res_cnt_q)))
    else $error("result buffer changed while stalled");

endmodule

FILE: test/tb_json_string_unescaper.sv
// self-checking testbench for the json string unescaper: directed and random byte streams
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0]       out_byte;
  logic             byte_valid;
  jsu_pkg::status_e status;
  jsu_pkg::err_e    error_code;
  logic             run_last;
} unescape_result_t;

// predicts the decoded bytes of each accepted item and checks them in order
class unescape_scoreboard;
  unescape_result_t pending_results[$];
  int unsigned      mismatches;
  int unsigned      items_noted;

  // decoder state mirrored from the block
  jsu_pkg::phase_e ph;
  logic [1:0]      hex_cnt;
  logic [15:0]     code_point;
  logic            hex_bad;

  function new();
    ph          = jsu_pkg::PH_WAIT;
    hex_cnt     = 2'd0;
    code_point  = 16'd0;
    hex_bad     = 1'b0;
    mismatches  = 0;
    items_noted = 0;
  endfunction

  // {ok, nibble}
  static function logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  // {ok, byte} for the one-byte escapes
  static function logic [8:0] escape_byte(logic [7:0] c);
    case (c)
      jsu_pkg::CH_QUOTE:     return {1'b1, jsu_pkg::CH_QUOTE};
      jsu_pkg::CH_BACKSLASH: return {1'b1, jsu_pkg::CH_BACKSLASH};
      jsu_pkg::CH_SLASH:     return {1'b1, jsu_pkg::CH_SLASH};
      "n":                   return {1'b1, 8'h0A};
      "r":                   return {1'b1, 8'h0D};
      "t":                   return {1'b1, 8'h09};
      "b":                   return {1'b1, 8'h08};
      "f":                   return {1'b1, 8'h0C};
      default:               return 9'd0;
    endcase
  endfunction

  function void push(logic [7:0] b, logic v, jsu_pkg::status_e st, jsu_pkg::err_e ec,
                     logic last);
    unescape_result_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.status     = st;
    r.error_code = ec;
    r.run_last   = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function void fail_to_wait(jsu_pkg::err_e ec);
    ph = jsu_pkg::PH_WAIT;
    push(8'd0, 1'b0, jsu_pkg::ST_ERR, ec, 1'b1);
  endfunction

  function void note_item(logic is_end, logic [7:0] c);
    logic [4:0] hx;
    logic [8:0] esc;
    items_noted++;
    case (ph)
      jsu_pkg::PH_BODY: begin
        if (is_end) begin
          fail_to_wait(jsu_pkg::ERR_UNTERM);
        end else if (c == jsu_pkg::CH_QUOTE) begin
          ph = jsu_pkg::PH_WAIT;
          push(8'd0, 1'b0, jsu_pkg::ST_DONE, jsu_pkg::ERR_NONE, 1'b1);
        end else if (c == jsu_pkg::CH_BACKSLASH) begin
          ph = jsu_pkg::PH_ESC;
          push(8'd0, 1'b0, jsu_pkg::ST_RUN, jsu_pkg::ERR_NONE, 1'b1);
        end else begin
          push(c, 1'b1, jsu_pkg::ST_RUN, jsu_pkg::ERR_NONE, 1'b1);
        end
      end
      jsu_pkg::PH_ESC: begin
        esc = escape_byte(c);
        if (is_end) begin
          fail_to_wait(jsu_pkg::ERR_TRUNC_ESC);
        end else if (c == jsu_pkg::CH_U) begin
          ph         = jsu_pkg::PH_HEX;
          hex_cnt    = 2'd0;
          code_point = 16'd0;
          hex_bad    = 1'b0;
          push(8'd0, 1'b0, jsu_pkg::ST_RUN, jsu_pkg::ERR_NONE, 1'b1);
        end else if (esc[8]) begin
          ph = jsu_pkg::PH_BODY;
          push(esc[7:0], 1'b1, jsu_pkg::ST_RUN, jsu_pkg::ERR_NONE, 1'b1);
        end else begin
          fail_to_wait(jsu_pkg::ERR_UNK_ESC);
        end
      end
      jsu_pkg::PH_HEX: begin
        hx = hex_nibble(c);
        if (is_end) begin
          fail_to_wait(jsu_pkg::ERR_TRUNC_UNI);
        end else begin
          if (!hx[4]) hex_bad = 1'b1;
          code_point = {code_point[11:0], hx[3:0]};
          if (hex_cnt != 2'd3) begin
            hex_cnt++;
            push(8'd0, 1'b0, jsu_pkg::ST_RUN, jsu_pkg::ERR_NONE, 1'b1);
          end else begin
            hex_cnt = 2'd0;
            if (hex_bad) begin
              fail_to_wait(jsu_pkg::ERR_BAD_HEX);
            end else begin
              ph = jsu_pkg::PH_BODY;
              if (code_point <= 16'h007F) begin
                push(code_point[7:0], 1'b1, jsu_pkg::ST_RUN, jsu_pkg::ERR_NONE, 1'b1);
              end else if (code_point <= 16'h07FF) begin
                push(jsu_pkg::UTF8_LEAD2 | 8'(code_point >> 6), 1'b1, jsu_pkg::ST_RUN,
                     jsu_pkg::ERR_NONE, 1'b0);
                push(jsu_pkg::UTF8_CONT | {2'b00, code_point[5:0]}, 1'b1, jsu_pkg::ST_RUN,
                     jsu_pkg::ERR_NONE, 1'b1);
              end else begin
                push(jsu_pkg::UTF8_LEAD3 | {4'h0, code_point[15:12]}, 1'b1, jsu_pkg::ST_RUN,
                     jsu_pkg::ERR_NONE, 1'b0);
                push(jsu_pkg::UTF8_CONT | {2'b00, code_point[11:6]}, 1'b1, jsu_pkg::ST_RUN,
                     jsu_pkg::ERR_NONE, 1'b0);
                push(jsu_pkg::UTF8_CONT | {2'b00, code_point[5:0]}, 1'b1, jsu_pkg::ST_RUN,
                     jsu_pkg::ERR_NONE, 1'b1);
              end
            end
          end
        end
      end
      default: begin
        if (is_end || c != jsu_pkg::CH_QUOTE) begin
          fail_to_wait(jsu_pkg::ERR_NO_QUOTE);
        end else begin
          ph = jsu_pkg::PH_BODY;
          push(8'd0, 1'b0, jsu_pkg::ST_RUN, jsu_pkg::ERR_NONE, 1'b1);
        end
      end
    endcase
  endfunction

  function void check_result(logic [7:0] ob, logic bv, logic [1:0] st, logic [2:0] ec,
                             logic rl);
    unescape_result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: out_byte %h status %0d error_code %0d", ob, st, ec);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (ob !== want.out_byte) begin
      $error("out_byte: expected %h, got %h", want.out_byte, ob);
      mismatches++;
    end
    if (bv !== want.byte_valid) begin
      $error("byte_valid: expected %0d, got %0d", want.byte_valid, bv);
      mismatches++;
    end
    if (st !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, st);
      mismatches++;
    end
    if (ec !== want.error_code) begin
      $error("error_code: expected %0d, got %0d", want.error_code, ec);
      mismatches++;
    end
    if (rl !== want.run_last) begin
      $error("run_last: expected %0d, got %0d", want.run_last, rl);
      mismatches++;
    end
  endfunction
endclass

module tb_json_string_unescaper;

  // func codes of an input item
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam int unsigned ITEM_COUNT   = 130;  // directed and random items together
  localparam int unsigned HOLD_CYCLES  = 60;   // long receiver hold-off
  localparam int unsigned SETTLE       = 8;    // settle margin beyond the two-stage pipeline
  localparam int unsigned IDLE_LIMIT   = 2000; // cycles with no item moving on either side

  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } src_item_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       func_i       = 1'b0;
  logic [7:0] in_byte_i    = 8'd0;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic [1:0] status_o;
  logic [2:0] error_code_o;
  logic       run_last_o;

  unescape_scoreboard sb;
  src_item_t          stim[$];
  int unsigned        n_directed;
  int unsigned        drain_at;
  int unsigned        hold_at;
  logic               rx_holding = 1'b0;
  int unsigned        idle_cycles = 0;

  json_string_unescaper uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .status_o     (status_o),
    .error_code_o (error_code_o),
    .run_last_o   (run_last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // stream building
  // ---------------------------------------------------------------------------------------

  function automatic void append_item(logic f, logic [7:0] d);
    src_item_t it;
    it.func = f;
    it.data = d;
    stim.insert(stim.size(), it);
  endfunction

  function automatic void add_byte(logic [7:0] c);
    append_item(FUNC_BYTE, c);
  endfunction

  // end of input, the byte lane carries noise
  function automatic void add_end();
    append_item(FUNC_END, 8'($urandom_range(0, 255)));
  endfunction

  // any byte that passes straight through the body
  function automatic void add_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BACKSLASH);
    add_byte(c);
  endfunction

  function automatic void add_simple_escape();
    logic [7:0] letters[8];
    letters = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH,
                "n", "r", "t", "b", "f"};
    add_byte(jsu_pkg::CH_BACKSLASH);
    add_byte(letters[$urandom_range(0, 7)]);
  endfunction

  // hex digit in either letter case
  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return "0" + 8'(nib);
    return ($urandom_range(0, 1) ? "A" : "a") + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (sb.hex_nibble(c) >= 5'h10);
    return c;
  endfunction

  // \u escape, spread over the one-, two- and three-byte utf-8 ranges and their edges
  function automatic void add_unicode();
    logic [15:0] cp;
    logic [15:0] edges[6];
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    case ($urandom_range(0, 3))
      0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
      1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
      2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
      default: cp = edges[$urandom_range(0, 5)];
    endcase
    add_byte(jsu_pkg::CH_BACKSLASH);
    add_byte(jsu_pkg::CH_U);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(cp[4*i +: 4]));
  endfunction

  function automatic void add_body(int unsigned n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: add_plain();
        5, 6, 7:       add_simple_escape();
        default:       add_unicode();
      endcase
    end
  endfunction

  // well-formed strings most of the time, broken ones and stray items otherwise
  function automatic void add_random_sequence();
    logic [7:0] c;
    int unsigned k;
    int unsigned bad_pos;
    if ($urandom_range(0, 99) < 70) begin
      add_byte(jsu_pkg::CH_QUOTE);
      add_body($urandom_range(0, 6));
      add_byte(jsu_pkg::CH_QUOTE);
      return;
    end
    case ($urandom_range(0, 6))
      0: add_end();                            // end with no string open
      1: add_byte(8'($urandom_range(0, 255))); // stray byte while waiting
      2: begin                                 // unterminated string
        add_byte(jsu_pkg::CH_QUOTE);
        add_body($urandom_range(0, 4));
        add_end();
      end
      3: begin                                 // cut off after the backslash
        add_byte(jsu_pkg::CH_QUOTE);
        add_body($urandom_range(0, 4));
        add_byte(jsu_pkg::CH_BACKSLASH);
        add_end();
      end
      4: begin                                 // \u cut short, digits may be bad
        add_byte(jsu_pkg::CH_QUOTE);
        add_body($urandom_range(0, 3));
        add_byte(jsu_pkg::CH_BACKSLASH);
        add_byte(jsu_pkg::CH_U);
        k = $urandom_range(0, 3);
        repeat (k) begin
          if ($urandom_range(0, 3) == 0) add_byte(bad_hex_char());
          else add_byte(hex_char(4'($urandom_range(0, 15))));
        end
        add_end();
      end
      5: begin                                 // four digits, at least one not hex
        add_byte(jsu_pkg::CH_QUOTE);
        add_body($urandom_range(0, 3));
        add_byte(jsu_pkg::CH_BACKSLASH);
        add_byte(jsu_pkg::CH_U);
        bad_pos = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
          if (i == bad_pos || $urandom_range(0, 5) == 0) add_byte(bad_hex_char());
          else add_byte(hex_char(4'($urandom_range(0, 15))));
        end
      end
      default: begin                           // escape letter outside the set
        add_byte(jsu_pkg::CH_QUOTE);
        add_body($urandom_range(0, 3));
        add_byte(jsu_pkg::CH_BACKSLASH);
        do begin
          c = 8'($urandom_range(0, 255));
        end while (c == jsu_pkg::CH_U || sb.escape_byte(c) >= 9'h100);
        add_byte(c);
      end
    endcase
  endfunction

  function automatic void build_directed();
    add_end();                       // end of input before any string
    add_byte(8'hFF);                 // non-quote byte while waiting
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(8'h00);                 // lowest byte passes through
    add_byte(jsu_pkg::CH_BACKSLASH); // \uFfaA: three utf-8 bytes, mixed-case digits
    add_byte(jsu_pkg::CH_U);
    add_byte("F");
    add_byte("f");
    add_byte("a");
    add_byte("A");
    add_byte(jsu_pkg::CH_QUOTE);     // done
    add_byte(jsu_pkg::CH_QUOTE);     // unknown escape letter
    add_byte(jsu_pkg::CH_BACKSLASH);
    add_byte("q");
    add_byte(jsu_pkg::CH_QUOTE);     // end right after a backslash
    add_byte(jsu_pkg::CH_BACKSLASH);
    add_end();
    add_byte(jsu_pkg::CH_QUOTE);     // end inside the body
    add_end();
    add_byte(jsu_pkg::CH_QUOTE);     // bad digit then end: truncation wins
    add_byte(jsu_pkg::CH_BACKSLASH);
    add_byte(jsu_pkg::CH_U);
    add_byte(8'h00);
    add_end();
    add_byte(jsu_pkg::CH_QUOTE);     // bad hex reported at the fourth digit
    add_byte(jsu_pkg::CH_BACKSLASH);
    add_byte(jsu_pkg::CH_U);
    add_byte("G");
    add_byte("1");
    add_byte("2");
    add_byte("3");
  endfunction

  // ---------------------------------------------------------------------------------------
  // sender: bursts of random length with random gaps, pauses to drain at two points
  // ---------------------------------------------------------------------------------------

  task automatic send_all();
    int unsigned burst_left;
    int unsigned gap;
    logic        taken;
    burst_left = $urandom_range(1, 12);
    foreach (stim[i]) begin
      if (i == n_directed || i == drain_at) begin
        // wait until every expected result has come out
        if (sb.pending_results.size() != 0) begin
          in_valid_i <= 1'b0;
          while (sb.pending_results.size() != 0) @(posedge clk_i);
        end
      end else if (burst_left == 0) begin
        // occasional long back-to-back stretches
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
        // keep offering items while the receiver holds off
        gap = rx_holding ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      if (burst_left != 0) burst_left--;
      in_valid_i <= 1'b1;
      func_i     <= stim[i].func;
      in_byte_i  <= stim[i].data;
      // stall is sampled mid-cycle, the item moves at the next rising edge
      do begin
        @(negedge clk_i);
        taken = !in_stall_o;
        @(posedge clk_i);
      end while (!taken);
      sb.note_item(stim[i].func, stim[i].data);
    end
  endtask

  initial begin : stimulus
    sb = new();
    build_directed();
    n_directed = stim.size();
    while (stim.size() < ITEM_COUNT) add_random_sequence();
    drain_at = n_directed + (stim.size() - n_directed) * 3 / 4;
    hold_at  = n_directed + 20;

    // reset held low at the start, then released
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_all();
    in_valid_i <= 1'b0;

    // drain, then let the pipeline settle to catch stray results
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // receiver: stall rate changes in random stretches, one long hold-off mid-run
  // ---------------------------------------------------------------------------------------

  initial begin : receiver
    int unsigned mode_left;
    int unsigned stall_pct;
    logic        hold_done;
    logic        got;
    logic [7:0]  ob;
    logic        bv;
    logic [1:0]  st;
    logic [2:0]  ec;
    logic        rl;
    mode_left = 0;
    stall_pct = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      got = out_valid_o && !out_stall_i;
      ob  = out_byte_o;
      bv  = byte_valid_o;
      st  = status_o;
      ec  = error_code_o;
      rl  = run_last_o;
      @(posedge clk_i);
      if (got) sb.check_result(ob, bv, st, ec, rl);

      // long hold-off so the block fills up and stalls its input
      if (!hold_done && sb.items_noted >= hold_at) begin
        hold_done  = 1'b1;
        rx_holding = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_holding = 1'b0;
      end

      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------------------
  // watchdog: counts cycles in which no item moves on either channel
  // ---------------------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
hdl/jsu_pkg.sv
hdl/json_string_unescaper.sv
test/tb_json_string_unescaper.sv
